// ===== sv/bsc_pkg.sv =====
// Shared types and constants for the banker's safety check block.
package bsc_pkg;

  // Hardware caps on processes and resources that a run can walk
  localparam int HW_MAX_PROCS = 16;
  localparam int HW_MAX_RES   = 16;

  // Default table geometry
  localparam int DEF_PROCS     = 16;
  localparam int DEF_RESOURCES = 16;

  // Count register width and reset value
  localparam int                  CNT_W     = 5;
  localparam logic [CNT_W-1:0]    CNT_RESET = 5'd16;

  // Configuration port geometry
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes (selected by the word address bit)
  localparam logic REG_PROC_COUNT = 1'b0;
  localparam logic REG_RES_COUNT  = 1'b1;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_WR_ALLOC = 2'd0,
    OP_WR_CLAIM = 2'd1,
    OP_WR_AVAIL = 2'd2,
    OP_RUN      = 2'd3
  } op_e;

  // Result kinds
  localparam logic KIND_SEQ     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_SAFE     = 2'd0;
  localparam logic [1:0] VERDICT_UNSAFE   = 2'd1;
  localparam logic [1:0] VERDICT_OVERCLAIM = 2'd2;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] proc_count;
    logic [CNT_W-1:0] res_count;
  } cfg_t;

endpackage

// ===== sv/bsc_cfg_regs.sv =====
// APB register block holding the process and resource counts.
module bsc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsc_pkg::APB_AW-1:0]  paddr,
  input  logic [bsc_pkg::APB_DW-1:0]  pwdata,
  output logic [bsc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output bsc_pkg::cfg_t               cfg_o
);

  logic [bsc_pkg::CNT_W-1:0] proc_count_q, proc_count_d;
  logic [bsc_pkg::CNT_W-1:0] res_count_q, res_count_d;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Update the addressed count on a write beat
  always_comb begin
    proc_count_d = proc_count_q;
    res_count_d  = res_count_q;
    if (wr_en) begin
      if (reg_sel == bsc_pkg::REG_PROC_COUNT) begin
        proc_count_d = pwdata[bsc_pkg::CNT_W-1:0];
      end else begin
        res_count_d = pwdata[bsc_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_count_q <= bsc_pkg::CNT_RESET;
      res_count_q  <= bsc_pkg::CNT_RESET;
    end else begin
      proc_count_q <= proc_count_d;
      res_count_q  <= res_count_d;
    end
  end

  // Return the addressed count on a read
  always_comb begin
    if (reg_sel == bsc_pkg::REG_PROC_COUNT) begin
      prdata = {{(bsc_pkg::APB_DW-bsc_pkg::CNT_W){1'b0}}, proc_count_q};
    end else begin
      prdata = {{(bsc_pkg::APB_DW-bsc_pkg::CNT_W){1'b0}}, res_count_q};
    end
  end

  assign cfg_o.proc_count = proc_count_q;
  assign cfg_o.res_count  = res_count_q;

endmodule

// ===== sv/bankers_safety_check.sv =====
// Top level: banker's algorithm safety check with table memories and a step sequencer.
//
// Usage. The input channel (valid/stall) carries one beat per operation:
// allocation, maximum-claim and available writes land in the tables in the
// accept cycle and give no result. A run beat starts the safety check; the
// block stalls its input until the run has loaded its final result beat.
// The output channel returns the safe sequence (one beat per granted
// process, kind 0) and then one verdict beat (kind 1, last high); an unsafe
// or over-claimed state returns only the verdict beat.
// Run. A run walks the tables one entry at a time through one table read port
// and one comparator/adder: the claim check over np*nr entries, loading work
// for each resource, then per pass a visit to each process, each resource
// tested and each resource added on a grant; at most np+1 passes. Results
// then leave at one beat per cycle while the output is not stalled.
// np and nr are the clamped proc_count and res_count registers (APB port).
// Reset clears the sequencer, the done flags and the output valid flag; the
// tables hold nothing valid until written. A stalled output holds its beat
// and the sequencer waits; a new run may be accepted while the final verdict
// of the previous one is still held.
module bankers_safety_check #(
  parameter int PROCS     = bsc_pkg::DEF_PROCS,
  parameter int RESOURCES = bsc_pkg::DEF_RESOURCES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsc_pkg::APB_AW-1:0]  paddr,
  input  logic [bsc_pkg::APB_DW-1:0]  pwdata,
  output logic [bsc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [3:0]                  proc_index_i,
  input  logic [3:0]                  res_index_i,
  input  logic [15:0]                 amount_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [3:0]                  granted_proc_o,
  output logic [1:0]                  verdict_o,
  output logic                        last_o
);

  localparam int PLIM      = (PROCS < bsc_pkg::HW_MAX_PROCS) ? PROCS : bsc_pkg::HW_MAX_PROCS;
  localparam int RLIM      = (RESOURCES < bsc_pkg::HW_MAX_RES) ? RESOURCES : bsc_pkg::HW_MAX_RES;
  localparam int PLW       = (PLIM > 1) ? $clog2(PLIM) : 1;
  localparam int RLW       = (RLIM > 1) ? $clog2(RLIM) : 1;
  localparam int TAB_DEPTH = PROCS * RESOURCES;
  localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int AVW       = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int CW        = bsc_pkg::CNT_W;
  localparam int WORK_W    = 21;

  localparam logic [CW-1:0] PLIM_C = CW'(PLIM);
  localparam logic [CW-1:0] RLIM_C = CW'(RLIM);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_CHK_RD  = 12'b0000_0000_0010,
    S_CHK_CMP = 12'b0000_0000_0100,
    S_INIT_RD = 12'b0000_0000_1000,
    S_INIT_WR = 12'b0000_0001_0000,
    S_PROC    = 12'b0000_0010_0000,
    S_FIT_RD  = 12'b0000_0100_0000,
    S_FIT_CMP = 12'b0000_1000_0000,
    S_ADD_RD  = 12'b0001_0000_0000,
    S_ADD_WR  = 12'b0010_0000_0000,
    S_NEXT    = 12'b0100_0000_0000,
    S_EMIT    = 12'b1000_0000_0000
  } state_e;

  bsc_pkg::cfg_t cfg;
  bsc_pkg::op_e  op;

  state_e             state_q, state_d;
  logic [PLW-1:0]     p_q, p_d;
  logic [RLW-1:0]     r_q, r_d;
  logic [CW-1:0]      np_q, np_d;
  logic [CW-1:0]      nr_q, nr_d;
  logic [CW-1:0]      seq_len_q, seq_len_d;
  logic [PLW-1:0]     e_q, e_d;
  logic               granted_q, granted_d;
  logic [2**PLW-1:0]  done_q, done_d;
  logic               emit_seq_q, emit_seq_d;
  logic [1:0]         pend_verdict_q, pend_verdict_d;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [3:0]         proc_q, proc_d;
  logic [1:0]         verdict_q, verdict_d;
  logic               last_q, last_d;

  // table memories
  logic [15:0]        alloc_mem [TAB_DEPTH];
  logic [15:0]        claim_mem [TAB_DEPTH];
  logic [15:0]        avail_mem [RESOURCES];
  logic [WORK_W-1:0]  work_mem  [2**RLW];
  logic [3:0]         seq_mem   [2**PLW];

  logic [15:0]        alloc_rd_q, claim_rd_q, avail_rd_q;
  logic [WORK_W-1:0]  work_rd_q;
  logic [3:0]         seq_rd_q;

  logic               in_accept;
  logic               slot_free;
  logic               row_ok, col_ok;
  logic [31:0]        wr_lin, rd_lin;
  logic [TAB_AW-1:0]  wr_addr, rd_addr;
  logic [31:0]        avail_wr_lin, avail_rd_lin;
  logic               work_we;
  logic [WORK_W-1:0]  work_wdata;
  logic               seq_we;
  logic               p_last, r_last, e_last;
  logic [15:0]        need;
  logic [2**PLW-1:0]  used_mask;
  logic               all_done;
  logic [CW-1:0]      np_clamp, nr_clamp;

  bsc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign op         = bsc_pkg::op_e'(operation_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign slot_free  = ~out_valid_q | ~out_stall_i;

  // Clamp the counts to the usable range
  always_comb begin
    if (cfg.proc_count == '0) np_clamp = CW'(1);
    else if (cfg.proc_count > PLIM_C) np_clamp = PLIM_C;
    else np_clamp = cfg.proc_count;
    if (cfg.res_count == '0) nr_clamp = CW'(1);
    else if (cfg.res_count > RLIM_C) nr_clamp = RLIM_C;
    else nr_clamp = cfg.res_count;
  end

  // Table addressing: write from the input beat, read from the walk counters
  assign row_ok       = 32'(proc_index_i) < 32'(PROCS);
  assign col_ok       = 32'(res_index_i) < 32'(RESOURCES);
  assign wr_lin       = 32'(proc_index_i) * 32'(RESOURCES) + 32'(res_index_i);
  assign rd_lin       = 32'(p_q) * 32'(RESOURCES) + 32'(r_q);
  assign wr_addr      = wr_lin[TAB_AW-1:0];
  assign rd_addr      = rd_lin[TAB_AW-1:0];
  assign avail_wr_lin = 32'(res_index_i);
  assign avail_rd_lin = 32'(r_q);

  always_ff @(posedge clk_i) begin
    if (in_accept && op == bsc_pkg::OP_WR_ALLOC && row_ok && col_ok) begin
      alloc_mem[wr_addr] <= amount_i;
    end
    if (in_accept && op == bsc_pkg::OP_WR_CLAIM && row_ok && col_ok) begin
      claim_mem[wr_addr] <= amount_i;
    end
    if (in_accept && op == bsc_pkg::OP_WR_AVAIL && col_ok) begin
      avail_mem[avail_wr_lin[AVW-1:0]] <= amount_i;
    end
    if (work_we) begin
      work_mem[r_q] <= work_wdata;
    end
    if (seq_we) begin
      seq_mem[seq_len_q[PLW-1:0]] <= 4'(p_q);
    end
    alloc_rd_q <= alloc_mem[rd_addr];
    claim_rd_q <= claim_mem[rd_addr];
    avail_rd_q <= avail_mem[avail_rd_lin[AVW-1:0]];
    work_rd_q  <= work_mem[r_q];
    // track the sequence entry that the emitter points at next
    seq_rd_q   <= seq_mem[e_d];
  end

  assign p_last = (CW'(p_q) == np_q - CW'(1));
  assign r_last = (CW'(r_q) == nr_q - CW'(1));
  assign e_last = (CW'(e_q) == seq_len_q - CW'(1));
  assign need   = claim_rd_q - alloc_rd_q;

  // Every used process finished
  always_comb begin
    for (int i = 0; i < 2**PLW; i++) begin
      used_mask[i] = (CW'(i) < np_q);
    end
  end
  assign all_done = &(done_q | ~used_mask);

  // Sequencer
  always_comb begin
    state_d        = state_q;
    p_d            = p_q;
    r_d            = r_q;
    np_d           = np_q;
    nr_d           = nr_q;
    seq_len_d      = seq_len_q;
    e_d            = e_q;
    granted_d      = granted_q;
    done_d         = done_q;
    emit_seq_d     = emit_seq_q;
    pend_verdict_d = pend_verdict_q;
    work_we        = 1'b0;
    work_wdata     = work_rd_q + WORK_W'(alloc_rd_q);
    seq_we         = 1'b0;
    out_valid_d    = out_valid_q & out_stall_i;
    kind_d         = kind_q;
    proc_d         = proc_q;
    verdict_d      = verdict_q;
    last_d         = last_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept && op == bsc_pkg::OP_RUN) begin
          np_d    = np_clamp;
          nr_d    = nr_clamp;
          p_d     = '0;
          r_d     = '0;
          state_d = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        state_d = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (alloc_rd_q > claim_rd_q) begin
          emit_seq_d     = 1'b0;
          pend_verdict_d = bsc_pkg::VERDICT_OVERCLAIM;
          state_d        = S_EMIT;
        end else if (r_last) begin
          r_d = '0;
          if (p_last) begin
            state_d = S_INIT_RD;
          end else begin
            p_d     = p_q + PLW'(1);
            state_d = S_CHK_RD;
          end
        end else begin
          r_d     = r_q + RLW'(1);
          state_d = S_CHK_RD;
        end
      end
      S_INIT_RD: begin
        state_d = S_INIT_WR;
      end
      S_INIT_WR: begin
        work_we    = 1'b1;
        work_wdata = WORK_W'(avail_rd_q);
        if (r_last) begin
          r_d       = '0;
          p_d       = '0;
          done_d    = '0;
          seq_len_d = '0;
          granted_d = 1'b0;
          state_d   = S_PROC;
        end else begin
          r_d     = r_q + RLW'(1);
          state_d = S_INIT_RD;
        end
      end
      S_PROC: begin
        r_d = '0;
        if (done_q[p_q]) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_FIT_RD;
        end
      end
      S_FIT_RD: begin
        state_d = S_FIT_CMP;
      end
      S_FIT_CMP: begin
        if (WORK_W'(need) > work_rd_q) begin
          state_d = S_NEXT;
        end else if (r_last) begin
          r_d     = '0;
          state_d = S_ADD_RD;
        end else begin
          r_d     = r_q + RLW'(1);
          state_d = S_FIT_RD;
        end
      end
      S_ADD_RD: begin
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        work_we = 1'b1;
        if (r_last) begin
          done_d[p_q] = 1'b1;
          seq_we      = 1'b1;
          seq_len_d   = seq_len_q + CW'(1);
          granted_d   = 1'b1;
          state_d     = S_NEXT;
        end else begin
          r_d     = r_q + RLW'(1);
          state_d = S_ADD_RD;
        end
      end
      S_NEXT: begin
        if (p_last) begin
          if (granted_q) begin
            granted_d = 1'b0;
            p_d       = '0;
            state_d   = S_PROC;
          end else if (all_done) begin
            emit_seq_d     = 1'b1;
            e_d            = '0;
            pend_verdict_d = bsc_pkg::VERDICT_SAFE;
            state_d        = S_EMIT;
          end else begin
            emit_seq_d     = 1'b0;
            pend_verdict_d = bsc_pkg::VERDICT_UNSAFE;
            state_d        = S_EMIT;
          end
        end else begin
          p_d     = p_q + PLW'(1);
          state_d = S_PROC;
        end
      end
      S_EMIT: begin
        // load the next result beat once the output register frees up
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (emit_seq_q) begin
            kind_d    = bsc_pkg::KIND_SEQ;
            proc_d    = seq_rd_q;
            verdict_d = bsc_pkg::VERDICT_SAFE;
            last_d    = 1'b0;
            if (e_last) begin
              emit_seq_d = 1'b0;
            end else begin
              e_d = e_q + PLW'(1);
            end
          end else begin
            kind_d    = bsc_pkg::KIND_VERDICT;
            proc_d    = '0;
            verdict_d = pend_verdict_q;
            last_d    = 1'b1;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      p_q            <= '0;
      r_q            <= '0;
      np_q           <= CW'(1);
      nr_q           <= CW'(1);
      seq_len_q      <= '0;
      e_q            <= '0;
      granted_q      <= 1'b0;
      done_q         <= '0;
      emit_seq_q     <= 1'b0;
      pend_verdict_q <= bsc_pkg::VERDICT_SAFE;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      p_q            <= p_d;
      r_q            <= r_d;
      np_q           <= np_d;
      nr_q           <= nr_d;
      seq_len_q      <= seq_len_d;
      e_q            <= e_d;
      granted_q      <= granted_d;
      done_q         <= done_d;
      emit_seq_q     <= emit_seq_d;
      pend_verdict_q <= pend_verdict_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    proc_q    <= proc_d;
    verdict_q <= verdict_d;
    last_q    <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign granted_proc_o = proc_q;
  assign verdict_o      = verdict_q;
  assign last_o         = last_q;

endmodule
